@@ sv/ftra_pkg.sv @@
// Shared types and constants for the fan tach rpm reader with divisor autoranging.
`default_nettype none
package ftra_pkg;

	localparam int unsigned RPM_W    = 21;
	localparam int unsigned DVSR_W   = 15;
	localparam int unsigned EXP_W    = 3;
	localparam int unsigned NUM_FANS = 3;

	localparam logic [RPM_W-1:0] RPM_CLOCK = 21'd1350000;

	localparam logic [1:0] FAN_A = 2'd0;
	localparam logic [1:0] FAN_B = 2'd1;
	localparam logic [1:0] FAN_C = 2'd2;
	localparam logic [1:0] FAN_NONE = 2'd3;

	localparam logic [3:0] CHIP_RESET = 4'd2;

	localparam logic [7:0] CNT_OVF = 8'hFF;

	// Everything in a result except the rpm value.
	typedef struct packed {
		logic       no_reading;
		logic       div_write_en;
		logic [7:0] div_write_byte;
		logic       pin_write_en;
		logic [7:0] pin_write_byte;
		logic       vctl_write_en;
		logic [7:0] vctl_write_byte;
	} res_t;

	// Overflow ranging: 0..2 step up, anything larger wraps to 0.
	function automatic logic [EXP_W-1:0] step_exp(input logic [EXP_W-1:0] e);
		logic [EXP_W-1:0] r;
		r = (e < 3'd3) ? e + 3'd1 : 3'd0;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/fan_tach_rpm_autorange.sv @@
// Fan tach reader: rebuilds divisor exponents, autoranges on overflow, bit-serial rpm divide.
//
//  channel   | group                         | contents
//  ----------+-------------------------------+---------------------------------------------
//  input     | s_tvalid s_tready s_tdata/user | tach count, register bytes, fan number
//  output    | m_tvalid m_tready m_tdata/user | rpm, register write-backs, no-reading flag
//  config    | cfg_we cfg_wdata               | chip type, written on any edge with cfg_we
//
// A reading with a valid count is accepted, runs through the restoring divider (one quotient bit
// per cycle), and is then loaded into the output register.
// Overflow, zero count and absent fans skip the divider.
// The next request is taken once the previous result has moved to the output register,
// so a stalled output holds at most one finished result plus one in the divider.
// Reset sets chip type 2 and all three divisor exponents to 1.
`default_nettype none
module fan_tach_rpm_autorange (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [3:0]  cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // tach_count, fan_div_byte, pin_ctrl_byte, volt_ctrl_byte
	input  wire  [1:0]  s_tuser,   // fan_select
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // rpm, div_write_en, div_write_byte, pin_write_en,
	                               // pin_write_byte, vctl_write_en, vctl_write_byte
	output logic        m_tuser    // no_reading
);
	import ftra_pkg::*;

	localparam int unsigned CNT_W = $clog2(RPM_W + 1);

	logic [3:0]        chip_q;
	logic [EXP_W-1:0]  exp_q [0:NUM_FANS-1];
	logic [EXP_W-1:0]  exp_n [0:NUM_FANS-1];

	logic              busy_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DVSR_W-1:0] rem_q;
	logic [RPM_W-1:0]  quo_q;
	res_t              pend_q;

	logic              out_vld_q;
	logic [RPM_W-1:0]  out_rpm_q;
	res_t              out_res_q;

	logic [1:0]        fan;
	logic [7:0]        cnt, db, pb, vb;
	logic              has_vctl, has_pin, skip, in_fire, ld;
	logic [EXP_W-1:0]  e_sel;
	logic [DVSR_W-1:0] dvsr;
	res_t              res;
	logic              div_go;
	logic [DVSR_W:0]   trial, diff;
	logic              ge;

	assign fan      = s_tuser;
	assign cnt      = s_tdata[7:0];
	assign db       = s_tdata[15:8];
	assign pb       = s_tdata[23:16];
	assign has_vctl = (chip_q >= 4'd2) && (chip_q <= 4'd6);
	assign has_pin  = (chip_q < 4'd11);
	assign vb       = has_vctl ? s_tdata[31:24] : 8'd0;
	assign skip     = (fan == FAN_NONE) ||
	                  ((fan == FAN_C) && (chip_q == 4'd6 || chip_q == 4'd10 || chip_q == 4'd13));

	assign s_tready = !busy_q;
	assign in_fire  = s_tvalid && s_tready;

	always_comb begin
		exp_n  = exp_q;
		res    = '0;
		res.no_reading = 1'b1;
		div_go = 1'b0;
		e_sel  = '0;
		dvsr   = '0;
		if (!skip) begin
			if (fan != FAN_C) begin
				exp_n[0] = {vb[5], db[5:4]};
				exp_n[1] = {vb[6], db[7:6]};
			end else if (has_pin) begin
				exp_n[2] = {vb[7], pb[7:6]};
			end
			if (cnt == CNT_OVF) begin
				if (fan != FAN_C) begin
					if (fan == FAN_A) begin
						exp_n[0] = step_exp(exp_n[0]);
					end else begin
						exp_n[1] = step_exp(exp_n[1]);
					end
					res.div_write_en   = 1'b1;
					res.div_write_byte = {exp_n[1][1:0], exp_n[0][1:0], db[3:0]};
				end else if (has_pin) begin
					exp_n[2] = step_exp(exp_n[2]);
					res.pin_write_en   = 1'b1;
					res.pin_write_byte = {exp_n[2][1:0], pb[5:0]};
				end
				if (has_vctl) begin
					res.vctl_write_en   = 1'b1;
					res.vctl_write_byte = {exp_n[2][2], exp_n[1][2], exp_n[0][2], vb[4:0]};
				end
			end else if (cnt != 8'd0) begin
				res.no_reading = 1'b0;
				div_go = 1'b1;
				unique case (fan)
					FAN_A:   e_sel = exp_n[0];
					FAN_B:   e_sel = exp_n[1];
					default: e_sel = exp_n[2];
				endcase
				dvsr = {{(DVSR_W-8){1'b0}}, cnt} << e_sel;
			end
		end
	end

	// Restoring divide step: one quotient bit enters quo_q as a dividend bit leaves.
	assign trial = {rem_q, quo_q[RPM_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = (trial >= {1'b0, dvsr_q});
	assign ld    = busy_q && (div_cnt_q == '0) && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_q    <= CHIP_RESET;
			for (int i = 0; i < NUM_FANS; i++) exp_q[i] <= 3'd1;
			busy_q    <= 1'b0;
			div_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				chip_q <= cfg_wdata;
			end
			if (in_fire) begin
				exp_q     <= exp_n;
				busy_q    <= 1'b1;
				div_cnt_q <= div_go ? CNT_W'(RPM_W) : '0;
			end else if (busy_q && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end else if (ld) begin
				busy_q <= 1'b0;
			end
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pend_q <= res;
			dvsr_q <= dvsr;
			rem_q  <= '0;
			quo_q  <= RPM_CLOCK;
		end else if (busy_q && div_cnt_q != '0) begin
			rem_q <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
			quo_q <= {quo_q[RPM_W-2:0], ge};
		end
		if (ld) begin
			out_res_q <= pend_q;
			out_rpm_q <= pend_q.no_reading ? '0 : quo_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_res_q.no_reading;
	assign m_tdata  = {out_res_q.vctl_write_byte, out_res_q.vctl_write_en,
	                   out_res_q.pin_write_byte, out_res_q.pin_write_en,
	                   out_res_q.div_write_byte, out_res_q.div_write_en, out_rpm_q};

	a_nr_zero_rpm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[RPM_W-1:0] == '0)
		else $error("rpm nonzero on a no-reading result");

	a_read_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[21] && !m_tdata[30] && !m_tdata[39])
		else $error("write-back on a valid reading");

	a_read_rpm_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[RPM_W-1:0] != '0)
		else $error("valid reading gave zero rpm");

	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q != '0 |-> busy_q)
		else $error("divider running while idle");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("second request taken while first in divider");

endmodule
`default_nettype wire
